// ===== design/ealut_pkg.sv =====
// Shared types and constants for the electrical angle unit with error table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ealut_pkg;

    // Angle format: unsigned fraction of one turn, 2^ANGLE_BITS being one turn.
    localparam int ANGLE_BITS  = 16;
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = ANGLE_BITS - IDX_BITS;

    // Field widths of the stream payloads.
    localparam int ENTRY_W     = 16;
    localparam int ENTRY_IDX_W = 7;
    localparam int POLE_W      = 8;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    // Interpolation products: entry times a weight of FRAC_BITS + 1 bits, plus headroom.
    localparam int PROD_W      = ENTRY_W + FRAC_BITS + 2;

    // Configuration port.
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_OFFSET   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLE_PAIRS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE        = 2'd2;

    // Item kinds carried on tuser.
    localparam logic FUNC_SAMPLE      = 1'b0;
    localparam logic FUNC_TABLE_WRITE = 1'b1;

    // Error table write request.
    typedef struct packed {
        logic                       en;
        logic [IDX_BITS-1:0]        addr;
        logic signed [ENTRY_W-1:0]  data;
    } t_tbl_wr;

endpackage

`default_nettype wire

// ===== design/ealut_table.sv =====
// Error table storage: one write port, two registered read ports.
// Entries not yet written read as zero through a row of valid flags. Uses ealut_pkg.
`default_nettype none

module ealut_table (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ealut_pkg::t_tbl_wr                     i_wr,
    input  wire logic                                   i_rd_en,
    input  wire logic [ealut_pkg::IDX_BITS-1:0]         i_rd_addr0,
    input  wire logic [ealut_pkg::IDX_BITS-1:0]         i_rd_addr1,
    output logic signed [ealut_pkg::ENTRY_W-1:0]        o_rd_data0,
    output logic signed [ealut_pkg::ENTRY_W-1:0]        o_rd_data1
);

    logic [ealut_pkg::ENTRY_W-1:0]     mem [ealut_pkg::TABLE_DEPTH];
    logic [ealut_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [ealut_pkg::ENTRY_W-1:0]     r_rd0;
    logic [ealut_pkg::ENTRY_W-1:0]     r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Writes and reads never come from the same transfer, so a read always sees
    // every earlier write without forwarding.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= r_valid[i_rd_addr0] ? mem[i_rd_addr0] : '0;
            r_rd1 <= r_valid[i_rd_addr1] ? mem[i_rd_addr1] : '0;
        end
    end

    assign o_rd_data0 = $signed(r_rd0);
    assign o_rd_data1 = $signed(r_rd1);

endmodule

`default_nettype wire

// ===== design/ealut_interp.sv =====
// Linear interpolation between two neighbouring error table entries.
// Registers the two weighted products, then sums and rounds. Uses ealut_pkg.
`default_nettype none

module ealut_interp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [ealut_pkg::ENTRY_W-1:0]   i_e0,
    input  wire logic signed [ealut_pkg::ENTRY_W-1:0]   i_e1,
    input  wire logic [ealut_pkg::FRAC_BITS-1:0]        i_frac,
    output logic [ealut_pkg::ANGLE_BITS-1:0]            o_corr
);

    localparam logic [ealut_pkg::FRAC_BITS:0] WeightOne =
        (ealut_pkg::FRAC_BITS+1)'(1) << ealut_pkg::FRAC_BITS;
    localparam logic signed [ealut_pkg::PROD_W-1:0] RoundHalf =
        ealut_pkg::PROD_W'(1) << (ealut_pkg::FRAC_BITS - 1);

    logic [ealut_pkg::FRAC_BITS:0]          w0;
    logic [ealut_pkg::FRAC_BITS:0]          w1;
    logic signed [ealut_pkg::PROD_W-1:0]    n_p0;
    logic signed [ealut_pkg::PROD_W-1:0]    n_p1;
    logic signed [ealut_pkg::PROD_W-1:0]    r_p0;
    logic signed [ealut_pkg::PROD_W-1:0]    r_p1;
    logic signed [ealut_pkg::PROD_W-1:0]    sum;
    logic signed [ealut_pkg::PROD_W-1:0]    shifted;

    // The lower weight is one minus the fraction; both lie in [0, 2^FRAC_BITS].
    assign w0   = WeightOne - {1'b0, i_frac};
    assign w1   = {1'b0, i_frac};
    assign n_p0 = ealut_pkg::PROD_W'(i_e0) * ealut_pkg::PROD_W'($signed({1'b0, w0}));
    assign n_p1 = ealut_pkg::PROD_W'(i_e1) * ealut_pkg::PROD_W'($signed({1'b0, w1}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
    end

    // Round to nearest with ties upwards: add half, then floor by arithmetic shift.
    assign sum     = r_p0 + r_p1 + RoundHalf;
    assign shifted = sum >>> ealut_pkg::FRAC_BITS;
    assign o_corr  = shifted[ealut_pkg::ANGLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/electrical_angle_with_error_lut_unit.sv =====
// Top level of the electrical angle unit with interpolated encoder error table.
// Instantiates ealut_table and ealut_interp; uses ealut_pkg.
//
//  Channel    | Dir | Payload                                              | Per transfer
//  s_axis     | in  | tdata: raw_angle, entry_index, entry_value; tuser: func | one item
//  m_axis     | out | tdata: mech_angle, elec_angle_raw, elec_angle_comp     | one result
//  i_cfg_*    | in  | register index, write data                           | one register
//
// One input transfer can be taken every cycle. A sample passes three register stages
// (table read, multiply, then sum and output register) before its result is valid on
// the output. Table writes and samples while the pole pair count is zero give no result.
// The whole pipeline advances together; it stalls only while the output register holds
// a result that the sink does not take, and it accepts whenever that register is empty.
// Reset is synchronous and clears the table (all entries read as zero).
`default_nettype none

module electrical_angle_with_error_lut_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration write port.
    input  wire logic                                   i_cfg_we,
    input  wire logic [ealut_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire logic [ealut_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Input stream.
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata, lowest bit first: raw_angle[15:0], entry_index[22:16],
    // entry_value[38:23], zero pad[39].
    input  wire logic [ealut_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: func (0 angle sample, 1 error table write).
    input  wire logic                                   s_axis_tuser,
    // Output stream.
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata, lowest bit first: mech_angle[15:0], elec_angle_raw[31:16],
    // elec_angle_comp[47:32].
    output logic [ealut_pkg::OUT_DATA_W-1:0]            m_axis_tdata
);

    localparam int AW = ealut_pkg::ANGLE_BITS;

    // Configuration registers.
    logic [AW-1:0]                      r_angle_offset;
    logic [ealut_pkg::POLE_W-1:0]       r_pole_pairs;
    logic                               r_reverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset <= '0;
            r_pole_pairs   <= ealut_pkg::POLE_W'(1);
            r_reverse      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ealut_pkg::CFG_ANGLE_OFFSET: r_angle_offset <= i_cfg_wdata[AW-1:0];
                ealut_pkg::CFG_POLE_PAIRS:   r_pole_pairs   <= i_cfg_wdata[ealut_pkg::POLE_W-1:0];
                ealut_pkg::CFG_REVERSE:      r_reverse      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage moves when the output register is free or drained.
    logic r_v1, r_v2, r_v3;
    logic adv;
    logic accept;

    assign adv           = !r_v3 || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Unpack the input transfer.
    logic [AW-1:0]                          raw_angle;
    logic [ealut_pkg::ENTRY_IDX_W-1:0]      entry_index;
    logic signed [ealut_pkg::ENTRY_W-1:0]   entry_value;

    assign raw_angle   = s_axis_tdata[15:0];
    assign entry_index = s_axis_tdata[22:16];
    assign entry_value = $signed(s_axis_tdata[38:23]);

    // Table writes go straight into the memory in the cycle of their transfer.
    ealut_pkg::t_tbl_wr tbl_wr;

    assign tbl_wr.en   = accept && (s_axis_tuser == ealut_pkg::FUNC_TABLE_WRITE);
    assign tbl_wr.addr = entry_index[ealut_pkg::IDX_BITS-1:0];
    assign tbl_wr.data = entry_value;

    // Stage 0: offset removal and table addressing. The top mechanical angle bits
    // index the table; the neighbour above wraps from the last entry to the first.
    logic                               sample_go;
    logic [AW-1:0]                      mech0;
    logic [ealut_pkg::IDX_BITS-1:0]     idx0;
    logic [ealut_pkg::IDX_BITS-1:0]     idx1;

    assign sample_go = accept && (s_axis_tuser == ealut_pkg::FUNC_SAMPLE)
                       && (r_pole_pairs != '0);
    assign mech0     = raw_angle - r_angle_offset;
    assign idx0      = mech0[AW-1 -: ealut_pkg::IDX_BITS];
    assign idx1      = idx0 + ealut_pkg::IDX_BITS'(1);

    logic signed [ealut_pkg::ENTRY_W-1:0] e0;
    logic signed [ealut_pkg::ENTRY_W-1:0] e1;

    ealut_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_en    (adv),
        .i_rd_addr0 (idx0),
        .i_rd_addr1 (idx1),
        .o_rd_data0 (e0),
        .o_rd_data1 (e1)
    );

    // Stage 1: table data arrives; the angle and fraction travel alongside.
    logic [AW-1:0]                      r_mech1;
    logic [ealut_pkg::FRAC_BITS-1:0]    r_frac1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mech1 <= mech0;
            r_frac1 <= mech0[ealut_pkg::FRAC_BITS-1:0];
        end
    end

    // Stage 2: pole pair multiply in parallel with the interpolation products.
    logic [AW-1:0] r_mech2;
    logic [AW-1:0] r_elec2;
    logic [AW+ealut_pkg::POLE_W-1:0] elec_full;

    assign elec_full = r_mech1 * r_pole_pairs;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mech2 <= r_mech1;
            r_elec2 <= elec_full[AW-1:0];
        end
    end

    logic [AW-1:0] corr;

    ealut_interp u_interp (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_e0   (e0),
        .i_e1   (e1),
        .i_frac (r_frac1),
        .o_corr (corr)
    );

    // Stage 3: direction, correction and the output register. Negating zero stays
    // zero because the subtraction wraps at one turn.
    logic [AW-1:0] elec_dir;
    logic [AW-1:0] r_out_mech;
    logic [AW-1:0] r_out_raw;
    logic [AW-1:0] r_out_comp;

    assign elec_dir = r_reverse ? (AW'(0) - r_elec2) : r_elec2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_mech <= r_mech2;
            r_out_raw  <= elec_dir;
            r_out_comp <= elec_dir + corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= sample_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {r_out_comp, r_out_raw, r_out_mech};

endmodule

`default_nettype wire

// ===== design/ealut_checker.sv =====
// Port-level checks for the electrical angle unit, attached by bind.
// Sees only the top-level ports; uses ealut_pkg for widths.
`default_nettype none

module ealut_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tready,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [ealut_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // A result held back by the sink stays put until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output result changed or vanished while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // The input side never waits while the output register is free to move.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled although the output can advance");

    // Input readiness changes only through the output side.
    a_ready_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without an output stall");

endmodule

bind electrical_angle_with_error_lut_unit ealut_checker u_ealut_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for electrical_angle_with_error_lut_unit.
// Needs ealut_pkg and the unit's RTL; runs directed tests, then random phases.
`timescale 1ns / 100ps

module tb_top;

    // One result transfer, split into its three angle fields.
    typedef struct {
        logic [15:0] mech;
        logic [15:0] eraw;
        logic [15:0] ecomp;
    } t_angle_triplet;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [ealut_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [ealut_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // Fields from bit 0 up: raw_angle, entry_index, entry_value, one bit of zero padding.
    logic [ealut_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    // Single field: func.
    logic                                 s_axis_tuser = ealut_pkg::FUNC_SAMPLE;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // Fields from bit 0 up: mech_angle, elec_angle_raw, elec_angle_comp.
    logic [ealut_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

    // Predictor state: our own copy of the registers and of the error table.
    logic [15:0]                          offset_copy;
    logic [ealut_pkg::POLE_W-1:0]         pole_pairs_copy;
    logic                                 reverse_copy;
    logic signed [ealut_pkg::ENTRY_W-1:0] correction_table [ealut_pkg::TABLE_DEPTH];

    t_angle_triplet           pending_angles [$];
    int                       mismatch_count = 0;

    // Idling controls, switched by the test tasks.
    bit                       source_gaps = 1'b1;
    bit                       sink_stalls = 1'b1;
    int                       sink_hold = 0;

    electrical_angle_with_error_lut_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Length of an idle stretch, drawn from three ranges: the shortest most often, the longest rarely.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 6);
        else
            return $urandom_range(15, 40);
    endfunction

    // Expected angles for one sample transfer. The mechanical angle is the raw
    // angle less the offset, modulo one turn; the electrical angle is that times
    // the pole pairs modulo one turn, negated for a reversed sensor. The correction
    // interpolates between the table entry picked by the top seven bits of the
    // mechanical angle and its neighbour (the last entry wraps round to the first),
    // rounded to nearest with ties upwards.
    function automatic t_angle_triplet predict_angles(logic [15:0] raw);
        t_angle_triplet                  res;
        logic [ealut_pkg::IDX_BITS-1:0]  lo_idx;
        logic [ealut_pkg::IDX_BITS-1:0]  hi_idx;
        logic [16:0]                     frac;
        logic [16:0]                     lo_weight;
        longint                          acc;
        longint                          corr;
        res.mech  = raw - offset_copy;
        res.eraw  = res.mech * pole_pairs_copy;
        if (reverse_copy)
            res.eraw = 16'd0 - res.eraw;
        lo_idx    = res.mech[15:ealut_pkg::FRAC_BITS];
        hi_idx    = lo_idx + 1'b1;
        frac      = {1'b0, res.mech[ealut_pkg::FRAC_BITS-1:0],
                     {ealut_pkg::IDX_BITS{1'b0}}};
        lo_weight = 17'h10000 - frac;
        acc  = longint'(correction_table[lo_idx]) * longint'(lo_weight)
             + longint'(correction_table[hi_idx]) * longint'(frac);
        corr = (acc + 64'sd32768) >>> ealut_pkg::ANGLE_BITS;
        res.ecomp = res.eraw + corr[15:0];
        return res;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // One process watches both streams at the rising edge. Results are compared
    // first; an input transfer at the same edge can only come out later, so its
    // expectation is queued afterwards. Table writes go into the predictor's table
    // in transfer order, so later samples see them just as the block does.
    always @(posedge i_clk) begin
        t_angle_triplet want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_angles.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_angles.pop_front();
                    check_field("mech_angle", want.mech, m_axis_tdata[15:0]);
                    check_field("elec_angle_raw", want.eraw, m_axis_tdata[31:16]);
                    check_field("elec_angle_comp", want.ecomp, m_axis_tdata[47:32]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ealut_pkg::FUNC_TABLE_WRITE)
                    correction_table[s_axis_tdata[22:16]] = s_axis_tdata[38:23];
                else if (pole_pairs_copy != '0)
                    pending_angles.push_back(predict_angles(s_axis_tdata[15:0]));
            end
        end
    end

    // Sink side: ready by default, with random stalls of varying length.
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Present one item and hold it until the transfer; then maybe leave a gap.
    // Valid is only ever assigned once per falling edge.
    task automatic send_item(logic func, logic [15:0] raw, logic [6:0] idx,
                             logic [15:0] val);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, val, idx, raw};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        if (source_gaps && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_sample(logic [15:0] raw);
        send_item(ealut_pkg::FUNC_SAMPLE, raw, 7'($urandom), 16'($urandom));
    endtask

    task automatic send_table_write(logic [6:0] idx, logic [15:0] val);
        send_item(ealut_pkg::FUNC_TABLE_WRITE, 16'($urandom), idx, val);
    endtask

    // Let the block drain: stop the source, wait until every expected result is in, then idle on.
    // Table writes need no extra wait, as they land in the memory when they are transferred.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic cfg_write(logic [ealut_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            ealut_pkg::CFG_ANGLE_OFFSET: offset_copy     = data;
            ealut_pkg::CFG_POLE_PAIRS:   pole_pairs_copy = data[ealut_pkg::POLE_W-1:0];
            ealut_pkg::CFG_REVERSE:      reverse_copy    = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_registers(logic [15:0] offset, logic [7:0] poles, logic rev);
        cfg_write(ealut_pkg::CFG_ANGLE_OFFSET, offset);
        cfg_write(ealut_pkg::CFG_POLE_PAIRS, {8'd0, poles});
        cfg_write(ealut_pkg::CFG_REVERSE, {15'd0, rev});
    endtask

    // Reset values: no offset, one pole pair, forward, empty table.
    task automatic test_reset_defaults();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        wait_idle();
    endtask

    // Extreme entries, interpolation halfway between entries,
    // and the wrap from the last entry back to the first.
    task automatic test_table_interpolation();
        send_table_write(7'd0, 16'h7FFF);
        send_table_write(7'd127, 16'h8000);
        send_table_write(7'd1, 16'hFFFF);
        send_table_write(7'd64, 16'h1234);
        send_sample(16'h0000);
        send_sample(16'hFE00);
        send_sample(16'hFFFF);
        send_sample(16'h0100);
        send_sample(16'h8000);
        wait_idle();
    endtask

    // Largest offset and pole count with reversal, including the negation of a
    // zero angle; then zero pole pairs, where samples vanish but writes still land.
    task automatic test_register_extremes();
        write_all_registers(16'hFFFF, 8'd255, 1'b1);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        wait_idle();
        write_all_registers(16'h0000, 8'd0, 1'b0);
        send_sample(16'h1234);
        send_table_write(7'd2, 16'h4000);
        send_sample(16'hFFFF);
        wait_idle();
    endtask

    // Random phases, each under its own register setting. Mostly samples with
    // table writes mixed in; one phase runs without any idling, and one pauses
    // the source midway until every result has come back.
    task automatic test_random_phases();
        logic [15:0] offset;
        logic [7:0]  poles;
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 2))
                0: offset = 16'h0000;
                1: offset = 16'hFFFF;
                default: offset = 16'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0: poles = 8'd1;
                1: poles = 8'd255;
                default: poles = 8'($urandom_range(2, 254));
            endcase
            if (phase == 0)
                write_all_registers(16'hFFFF, 8'd255, 1'b1);
            else if (phase == 1)
                write_all_registers(16'h0000, 8'd1, 1'b0);
            else
                write_all_registers(offset, poles, 1'($urandom));
            source_gaps = (phase != 3);
            sink_stalls = (phase != 3);
            for (int n = 0; n < 100; n++) begin
                if (phase == 2 && n == 50)
                    wait_idle();
                if ($urandom_range(0, 3) == 0)
                    send_table_write(7'($urandom), 16'($urandom));
                else
                    send_sample(16'($urandom));
            end
            wait_idle();
            source_gaps = 1'b1;
            sink_stalls = 1'b1;
        end
    endtask

    initial begin
        offset_copy     = '0;
        pole_pairs_copy = 8'd1;
        reverse_copy    = 1'b0;
        foreach (correction_table[k])
            correction_table[k] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_table_interpolation();
        test_register_extremes();
        test_random_phases();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ealut_pkg.sv
design/ealut_table.sv
design/ealut_interp.sv
design/electrical_angle_with_error_lut_unit.sv
design/ealut_checker.sv
tb/tb_top.sv
